// ----- sv/tlwm_pkg.sv -----
// Shared constants and types for the text line width meter.
package tlwm_pkg;

	localparam int GLYPH_SLOTS  = 256;
	localparam int SLOT_BITS    = $clog2(GLYPH_SLOTS);
	localparam int METRIC_BITS  = 24;
	localparam int OUT_BITS     = 24;
	localparam int COUNT_BITS   = 16;
	localparam int CFG_BITS     = 10;
	localparam int BYTE_BITS    = 8;
	localparam int CODE_BITS    = 21;
	localparam int PROD_BITS    = COUNT_BITS + CFG_BITS;
	// wide enough for a metric plus two 10-bit terms, and for the height product
	localparam int CALC_BITS    = 34;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [METRIC_BITS-1:0] metric_t;
	typedef logic [COUNT_BITS-1:0]  count_t;

	localparam metric_t METRIC_MAX = '1;
	localparam count_t  COUNT_MAX  = '1;

	localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SPACE_WIDTH,
		REG_CHAR_SPACING,
		REG_LINE_HEIGHT,
		REG_UTF8_MODE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_BREAK,
		EV_SPACE,
		EV_GLYPH
	} char_ev_t;

endpackage

// ----- sv/tlwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tlwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/text_line_width_meter.sv -----
// Top level: byte-stream text line width and height meter.
// The block takes one item per clock while item_stall is low: a glyph width write or one text byte. Text bytes are
// decoded (ASCII or UTF-8) and looked up in the glyph table in the first stage, then the
// line sums are updated in the second; the result for a byte marked last is loaded into the
// result register when that byte leaves the first stage. item_stall rises only when a
// last byte sits in the first stage while the previous result is still held by a stalled
// result side. The glyph table is a GLYPH_SLOTS x 10 RAM with registered read, backed by
// present flags that reset clears at once, so there is no clearing pass.
module text_line_width_meter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tlwm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tlwm_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               action,
	input  logic [7:0]                         glyph_index,
	input  logic [tlwm_pkg::CFG_BITS-1:0]      glyph_width,
	input  logic [tlwm_pkg::BYTE_BITS-1:0]     text_byte,
	input  logic                               last_byte,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [tlwm_pkg::OUT_BITS-1:0]      string_width,
	output logic [tlwm_pkg::OUT_BITS-1:0]      string_height,
	output logic [tlwm_pkg::COUNT_BITS-1:0]    line_count
);

	import tlwm_pkg::*;

	// configuration
	logic [CFG_BITS-1:0] space_width_q;
	logic [CFG_BITS-1:0] char_spacing_q;
	logic [CFG_BITS-1:0] line_height_q;
	logic                utf8_mode_q;

	// decode state
	logic [1:0]           rem_q, rem_d;
	logic [CODE_BITS-1:0] accum_q, accum_d;
	logic                 cr_q, cr_d;
	logic [GLYPH_SLOTS-1:0] present_q;

	// stage 1
	logic     valid_s1;
	logic     last_s1;
	char_ev_t ev_s1;
	char_ev_t ev;

	// line state
	metric_t line_q, line_d;
	metric_t max_q, max_d, max_final;
	logic    has_q, has_d;
	count_t  lines_q, lines_d;

	logic [CODE_BITS-1:0] code;
	logic                 has_char;
	logic                 after_cr_eff;
	logic                 code_in_range;
	logic [SLOT_BITS-1:0] slot;
	logic                 idx_in_range;

	logic                 accept;
	logic                 text_accept;
	logic                 write_accept;
	logic                 out_free;
	logic                 adv2;
	logic                 load_s1;

	logic [CFG_BITS-1:0]  ram_rdata;
	logic [CFG_BITS-1:0]  w;
	logic [CALC_BITS-1:0] sum;
	logic [PROD_BITS-1:0] prod;
	metric_t              height;

	function automatic metric_t sat_metric(input logic [CALC_BITS-1:0] x);
		if (x > CALC_BITS'(METRIC_MAX)) begin
			return METRIC_MAX;
		end
		return metric_t'(x);
	endfunction

	// handshake
	assign out_free     = !result_valid || !result_stall;
	assign adv2         = valid_s1 && (!last_s1 || out_free);
	assign load_s1      = !valid_s1 || adv2;
	assign item_stall   = !load_s1;
	assign accept       = item_valid && load_s1;
	assign text_accept  = accept && action;
	assign write_accept = accept && !action;
	assign idx_in_range = 32'(glyph_index) < GLYPH_SLOTS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_width_q  <= '0;
			char_spacing_q <= '0;
			line_height_q  <= '0;
			utf8_mode_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPACE_WIDTH:  space_width_q  <= cfg_data;
				REG_CHAR_SPACING: char_spacing_q <= cfg_data;
				REG_LINE_HEIGHT:  line_height_q  <= cfg_data;
				REG_UTF8_MODE:    utf8_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// byte decode and character classification
	always_comb begin
		rem_d        = rem_q;
		accum_d      = accum_q;
		code         = CODE_BITS'(text_byte);
		has_char     = 1'b0;
		after_cr_eff = cr_q;
		if (!utf8_mode_q) begin
			rem_d    = '0;
			has_char = 1'b1;
		end else if (rem_q != '0 && text_byte[7:6] == 2'b10) begin
			accum_d = {accum_q[CODE_BITS-7:0], text_byte[5:0]};
			rem_d   = rem_q - 2'd1;
			if (rem_d == '0) begin
				has_char     = 1'b1;
				code         = accum_d;
				after_cr_eff = 1'b0;
			end
		end else begin
			// a broken sequence is dropped and this byte starts over
			rem_d = '0;
			if (!text_byte[7]) begin
				has_char = 1'b1;
			end else if (text_byte[7:5] == 3'b110) begin
				accum_d = CODE_BITS'(text_byte[4:0]);
				rem_d   = 2'd1;
			end else if (text_byte[7:4] == 4'b1110) begin
				accum_d = CODE_BITS'(text_byte[3:0]);
				rem_d   = 2'd2;
			end else if (text_byte[7:3] == 5'b11110) begin
				accum_d = CODE_BITS'(text_byte[2:0]);
				rem_d   = 2'd3;
			end
		end

		code_in_range = 32'(code) < GLYPH_SLOTS;
		slot          = SLOT_BITS'(code);
		ev            = EV_NONE;
		cr_d          = 1'b0;
		if (has_char) begin
			if (code == CODE_BITS'(CHAR_CR)) begin
				ev   = EV_BREAK;
				cr_d = 1'b1;
			end else if (code == CODE_BITS'(CHAR_LF)) begin
				ev = after_cr_eff ? EV_NONE : EV_BREAK;
			end else if (code == CODE_BITS'(CHAR_SPACE)) begin
				ev = EV_SPACE;
			end else if (code_in_range && present_q[slot]) begin
				ev = EV_GLYPH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			accum_q   <= '0;
			cr_q      <= 1'b0;
			present_q <= '0;
		end else begin
			if (text_accept) begin
				if (last_byte) begin
					rem_q   <= '0;
					accum_q <= '0;
					cr_q    <= 1'b0;
				end else begin
					rem_q   <= rem_d;
					accum_q <= accum_d;
					cr_q    <= cr_d;
				end
			end
			if (write_accept && idx_in_range) begin
				present_q[SLOT_BITS'(glyph_index)] <= 1'b1;
			end
		end
	end

	tlwm_ram #(
		.WIDTH(CFG_BITS),
		.DEPTH(GLYPH_SLOTS)
	) u_glyph_ram (
		.clk  (clk),
		.we   (write_accept && idx_in_range),
		.waddr(SLOT_BITS'(glyph_index)),
		.wdata(glyph_width),
		.re   (text_accept),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= text_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (text_accept) begin
			last_s1 <= last_byte;
			ev_s1   <= ev;
		end
	end

	// line sums
	always_comb begin
		line_d  = line_q;
		max_d   = max_q;
		has_d   = has_q;
		lines_d = lines_q;
		w       = (ev_s1 == EV_SPACE) ? space_width_q : ram_rdata;
		sum     = CALC_BITS'(line_q) + (has_q ? CALC_BITS'(char_spacing_q) : '0)
		        + CALC_BITS'(w);
		case (ev_s1)
			EV_BREAK: begin
				if (line_q > max_q) begin
					max_d = line_q;
				end
				line_d = '0;
				has_d  = 1'b0;
				if (lines_q != COUNT_MAX) begin
					lines_d = lines_q + 1'b1;
				end
			end
			EV_SPACE, EV_GLYPH: begin
				line_d = sat_metric(sum);
				has_d  = 1'b1;
			end
			default: ;
		endcase
		max_final = (line_d > max_d) ? line_d : max_d;
		prod      = PROD_BITS'(lines_d) * PROD_BITS'(line_height_q);
		height    = sat_metric(CALC_BITS'(prod));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= '0;
			max_q   <= '0;
			has_q   <= 1'b0;
			lines_q <= COUNT_BITS'(1);
		end else if (adv2) begin
			if (last_s1) begin
				line_q  <= '0;
				max_q   <= '0;
				has_q   <= 1'b0;
				lines_q <= COUNT_BITS'(1);
			end else begin
				line_q  <= line_d;
				max_q   <= max_d;
				has_q   <= has_d;
				lines_q <= lines_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv2 && last_s1) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && last_s1) begin
			string_width  <= OUT_BITS'(max_final);
			string_height <= OUT_BITS'(height);
			line_count    <= lines_d;
		end
	end

endmodule

// ----- sv/tlwm_checker.sv -----
// Port-level checker for the text line width meter, bound to the top level.
module tlwm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input logic                            action,
	input logic                            last_byte,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [tlwm_pkg::OUT_BITS-1:0]   string_width,
	input logic [tlwm_pkg::OUT_BITS-1:0]   string_height,
	input logic [tlwm_pkg::COUNT_BITS-1:0] line_count
);

	// a new result is loaded when its last text byte leaves the first stage, so each
	// rise of result_valid traces back to an accepted last text byte
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall && action && last_byte, 2))
		else $error("result without a last text byte two clocks earlier");

	// input side only backs up behind a held, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("item stall without a stalled result");

	// every string has at least one line
	a_line_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (line_count != '0))
		else $error("result with zero lines");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(string_width) && $stable(string_height)
			 && $stable(line_count)))
		else $error("stalled result changed");

endmodule

bind text_line_width_meter tlwm_checker u_tlwm_checker (.*);
